>>> hdl/gmds_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmds_pkg - shared types, codes and microcode for the grid maze solver
// Holds the control word layout, the condition and operation codes, the
// microprogram table and the goal test used by sequencer and datapath.
// ----------------------------------------------------------------------------
package gmds_pkg;

    // Default grid limits
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // Field widths
    localparam int COORD_W = 6;
    localparam int COUNT_W = 7;
    localparam int CHAR_W  = 8;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int DIM_W   = 9;   // holds any coordinate or count up to 256
    localparam int DIR_W   = 3;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SOLVE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL = 2'd3;

    // Cell characters
    localparam logic [CHAR_W-1:0] CH_OPEN = 8'h20;
    localparam logic [CHAR_W-1:0] CH_SEEN = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DEAD = 8'h2F;

    // Search directions, tried in this order
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

    // Microprogram step addresses
    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step U_RESP        = 5'd0;
    localparam t_step U_IDLE        = 5'd1;
    localparam t_step U_DISP        = 5'd2;
    localparam t_step U_CHK_UNK     = 5'd3;
    localparam t_step U_CHK_ADDR    = 5'd4;
    localparam t_step U_CHK_WR      = 5'd5;
    localparam t_step U_RD_ISSUE    = 5'd6;
    localparam t_step U_RD_TAKE     = 5'd7;
    localparam t_step U_WR          = 5'd8;
    localparam t_step U_BAD_ADDR    = 5'd9;
    localparam t_step U_SOLVE       = 5'd10;
    localparam t_step U_ENTER_START = 5'd11;
    localparam t_step U_TRY         = 5'd12;
    localparam t_step U_CHK_DIR     = 5'd13;
    localparam t_step U_NEXT        = 5'd14;
    localparam t_step U_RD_NB       = 5'd15;
    localparam t_step U_CHK_NB      = 5'd16;
    localparam t_step U_MARK_NB     = 5'd17;
    localparam t_step U_PUSH        = 5'd18;
    localparam t_step U_POP         = 5'd19;
    localparam t_step U_RELOAD      = 5'd20;
    localparam t_step U_FOUND       = 5'd21;
    localparam t_step U_START_BAD   = 5'd22;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_ACC,
        C_REQ_SOLVE,
        C_REQ_UNK,
        C_REQ_OUT,
        C_REQ_WRITE,
        C_START_OUT,
        C_START_GOAL,
        C_EMPTY,
        C_DIR_DONE,
        C_NB_WALL,
        C_NB_CLOSED,
        C_NB_GOAL,
        C_OUT_BUSY
    } t_cond;

    // Maze memory operations
    typedef enum logic [2:0] {
        MZ_NONE,
        MZ_RD_REQ,
        MZ_WR_REQ,
        MZ_WR_SEEN_START,
        MZ_RD_NB,
        MZ_WR_SEEN_NB,
        MZ_WR_DEAD_TOP
    } t_mz_op;

    // Search stack and top-frame operations
    typedef enum logic [2:0] {
        ST_NONE,
        ST_INIT,
        ST_NEXT,
        ST_PUSH,
        ST_POP,
        ST_LOAD,
        ST_CLEAR
    } t_st_op;

    // Result register operations
    typedef enum logic [2:0] {
        RES_NONE,
        RES_CAPTURE,
        RES_BAD,
        RES_FLAG_CLR,
        RES_FLAG_SET,
        RES_BAD_CLR,
        RES_SEND
    } t_res_op;

    typedef struct packed {
        logic    in_rdy;
        t_cond   cond;
        t_step   jmp;
        t_mz_op  mz;
        t_st_op  st;
        t_res_op res;
    } t_uword;

    // Condition inputs seen by the sequencer
    typedef struct packed {
        logic not_acc;
        logic req_solve;
        logic req_unk;
        logic req_out;
        logic req_write;
        logic start_out;
        logic start_goal;
        logic empty;
        logic dir_done;
        logic nb_wall;
        logic nb_closed;
        logic nb_goal;
        logic out_busy;
    } t_flags;

    // Status from the datapath
    typedef struct packed {
        logic start_goal;
        logic empty;
        logic dir_done;
        logic nb_wall;
        logic nb_closed;
        logic nb_goal;
    } t_dp_stat;

    function automatic t_uword uw_make(input logic rdy, input t_cond c, input t_step j,
                                       input t_mz_op m, input t_st_op s, input t_res_op r);
        t_uword w;
        w.in_rdy = rdy;
        w.cond   = c;
        w.jmp    = j;
        w.mz     = m;
        w.st     = s;
        w.res    = r;
        return w;
    endfunction

    // Microprogram: jump to jmp when the condition holds, else fall through
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        unique case (step)
            U_RESP:        w = uw_make(1'b0, C_OUT_BUSY,   U_RESP,      MZ_NONE,
                                       ST_NONE,  RES_SEND);
            U_IDLE:        w = uw_make(1'b1, C_NOT_ACC,    U_IDLE,      MZ_NONE,
                                       ST_NONE,  RES_NONE);
            U_DISP:        w = uw_make(1'b0, C_REQ_SOLVE,  U_SOLVE,     MZ_NONE,
                                       ST_NONE,  RES_NONE);
            U_CHK_UNK:     w = uw_make(1'b0, C_REQ_UNK,    U_RESP,      MZ_NONE,
                                       ST_NONE,  RES_NONE);
            U_CHK_ADDR:    w = uw_make(1'b0, C_REQ_OUT,    U_BAD_ADDR,  MZ_NONE,
                                       ST_NONE,  RES_NONE);
            U_CHK_WR:      w = uw_make(1'b0, C_REQ_WRITE,  U_WR,        MZ_NONE,
                                       ST_NONE,  RES_NONE);
            U_RD_ISSUE:    w = uw_make(1'b0, C_NEVER,      U_IDLE,      MZ_RD_REQ,
                                       ST_NONE,  RES_NONE);
            U_RD_TAKE:     w = uw_make(1'b0, C_ALWAYS,     U_RESP,      MZ_NONE,
                                       ST_NONE,  RES_CAPTURE);
            U_WR:          w = uw_make(1'b0, C_ALWAYS,     U_RESP,      MZ_WR_REQ,
                                       ST_NONE,  RES_NONE);
            U_BAD_ADDR:    w = uw_make(1'b0, C_ALWAYS,     U_RESP,      MZ_NONE,
                                       ST_NONE,  RES_BAD);
            U_SOLVE:       w = uw_make(1'b0, C_START_OUT,  U_START_BAD, MZ_NONE,
                                       ST_NONE,  RES_NONE);
            U_ENTER_START: w = uw_make(1'b0, C_START_GOAL, U_FOUND,     MZ_WR_SEEN_START,
                                       ST_INIT,  RES_FLAG_CLR);
            U_TRY:         w = uw_make(1'b0, C_EMPTY,      U_RESP,      MZ_NONE,
                                       ST_NONE,  RES_NONE);
            U_CHK_DIR:     w = uw_make(1'b0, C_DIR_DONE,   U_POP,       MZ_NONE,
                                       ST_NONE,  RES_NONE);
            U_NEXT:        w = uw_make(1'b0, C_NB_WALL,    U_TRY,       MZ_NONE,
                                       ST_NEXT,  RES_NONE);
            U_RD_NB:       w = uw_make(1'b0, C_NEVER,      U_IDLE,      MZ_RD_NB,
                                       ST_NONE,  RES_NONE);
            U_CHK_NB:      w = uw_make(1'b0, C_NB_CLOSED,  U_TRY,       MZ_NONE,
                                       ST_NONE,  RES_NONE);
            U_MARK_NB:     w = uw_make(1'b0, C_NB_GOAL,    U_FOUND,     MZ_WR_SEEN_NB,
                                       ST_NONE,  RES_NONE);
            U_PUSH:        w = uw_make(1'b0, C_ALWAYS,     U_TRY,       MZ_NONE,
                                       ST_PUSH,  RES_NONE);
            U_POP:         w = uw_make(1'b0, C_NEVER,      U_IDLE,      MZ_WR_DEAD_TOP,
                                       ST_POP,   RES_NONE);
            U_RELOAD:      w = uw_make(1'b0, C_ALWAYS,     U_TRY,       MZ_NONE,
                                       ST_LOAD,  RES_NONE);
            U_FOUND:       w = uw_make(1'b0, C_ALWAYS,     U_RESP,      MZ_NONE,
                                       ST_CLEAR, RES_FLAG_SET);
            U_START_BAD:   w = uw_make(1'b0, C_ALWAYS,     U_RESP,      MZ_NONE,
                                       ST_NONE,  RES_BAD_CLR);
            default:       w = uw_make(1'b0, C_ALWAYS,     U_IDLE,      MZ_NONE,
                                       ST_NONE,  RES_NONE);
        endcase
        return w;
    endfunction

    // Goal sits at (rows-2, cols-1); no goal with fewer than two rows
    function automatic logic is_goal(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
                                     input logic [DIM_W-1:0] rows,
                                     input logic [DIM_W-1:0] cols);
        logic ok;
        ok = (rows >= DIM_W'(2)) && (cols != '0) &&
             (r == rows - DIM_W'(2)) && (c == cols - DIM_W'(1));
        return ok;
    endfunction

endpackage
`default_nettype wire

>>> hdl/gmds_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmds_ram - generic single-write, single-read RAM
// One write port and one read port per cycle, read data registered.
// ----------------------------------------------------------------------------
module gmds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/gmds_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmds_seq - microprogram sequencer
// Step counter, control store lookup and conditional jump selection.
// ----------------------------------------------------------------------------
module gmds_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire gmds_pkg::t_flags  i_flags,
    output gmds_pkg::t_uword       o_uw
);

    gmds_pkg::t_step  r_step;
    gmds_pkg::t_step  n_step;
    gmds_pkg::t_uword uw;
    logic             take;

    assign uw = gmds_pkg::ucode(r_step);

    always_comb begin
        unique case (uw.cond)
            gmds_pkg::C_NEVER:      take = 1'b0;
            gmds_pkg::C_ALWAYS:     take = 1'b1;
            gmds_pkg::C_NOT_ACC:    take = i_flags.not_acc;
            gmds_pkg::C_REQ_SOLVE:  take = i_flags.req_solve;
            gmds_pkg::C_REQ_UNK:    take = i_flags.req_unk;
            gmds_pkg::C_REQ_OUT:    take = i_flags.req_out;
            gmds_pkg::C_REQ_WRITE:  take = i_flags.req_write;
            gmds_pkg::C_START_OUT:  take = i_flags.start_out;
            gmds_pkg::C_START_GOAL: take = i_flags.start_goal;
            gmds_pkg::C_EMPTY:      take = i_flags.empty;
            gmds_pkg::C_DIR_DONE:   take = i_flags.dir_done;
            gmds_pkg::C_NB_WALL:    take = i_flags.nb_wall;
            gmds_pkg::C_NB_CLOSED:  take = i_flags.nb_closed;
            gmds_pkg::C_NB_GOAL:    take = i_flags.nb_goal;
            gmds_pkg::C_OUT_BUSY:   take = i_flags.out_busy;
            default:                take = 1'b0;
        endcase
        n_step = take ? uw.jmp : r_step + gmds_pkg::t_step'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= gmds_pkg::U_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_uw = uw;

endmodule
`default_nettype wire

>>> hdl/gmds_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gmds_dp - search datapath
// Maze memory, search stack memory, top-of-stack frame, neighbor logic.
// ----------------------------------------------------------------------------
module gmds_dp #(
    parameter int MAX_ROWS = gmds_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gmds_pkg::MAX_COLS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gmds_pkg::t_uword              i_uw,
    input  wire logic [gmds_pkg::DIM_W-1:0]    i_rows_used,
    input  wire logic [gmds_pkg::DIM_W-1:0]    i_cols_used,
    input  wire logic [gmds_pkg::COORD_W-1:0]  i_start_row,
    input  wire logic [gmds_pkg::COORD_W-1:0]  i_start_col,
    input  wire logic [gmds_pkg::COORD_W-1:0]  i_req_row,
    input  wire logic [gmds_pkg::COORD_W-1:0]  i_req_col,
    input  wire logic [gmds_pkg::CHAR_W-1:0]   i_req_char,
    output logic      [gmds_pkg::CHAR_W-1:0]   o_mz_rdata,
    output gmds_pkg::t_dp_stat                 o_stat
);

    localparam int DW    = gmds_pkg::DIM_W;
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int AW    = RW + CW;
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int SAW   = $clog2(CELLS);
    localparam int SDW   = $clog2(CELLS + 1);
    localparam int XW    = gmds_pkg::DIR_W;
    localparam int FW    = RW + CW + XW;

    logic [RW-1:0]  r_top_row, n_top_row;
    logic [CW-1:0]  r_top_col, n_top_col;
    logic [XW-1:0]  r_top_dir, n_top_dir;
    logic [RW-1:0]  r_nb_row,  n_nb_row;
    logic [CW-1:0]  r_nb_col,  n_nb_col;
    logic [SDW-1:0] r_depth,   n_depth;

    logic [DW-1:0]  top_r, top_c, nr, nc, start_r, start_c, req_r, req_c;
    logic           nb_wall;
    logic [SDW-1:0] depth_m1, depth_m2;

    logic [AW-1:0]  mz_waddr, mz_raddr;
    logic [gmds_pkg::CHAR_W-1:0] mz_wdata, mz_rdata;
    logic           mz_we;
    logic [AW-1:0]  top_addr, nb_addr, start_addr, req_addr;

    logic           st_we;
    logic [FW-1:0]  st_rdata;

    assign top_r   = DW'(r_top_row);
    assign top_c   = DW'(r_top_col);
    assign start_r = DW'(i_start_row);
    assign start_c = DW'(i_start_col);
    assign req_r   = DW'(i_req_row);
    assign req_c   = DW'(i_req_col);

    assign top_addr   = {r_top_row, r_top_col};
    assign nb_addr    = {r_nb_row, r_nb_col};
    assign start_addr = {start_r[RW-1:0], start_c[CW-1:0]};
    assign req_addr   = {req_r[RW-1:0], req_c[CW-1:0]};

    assign depth_m1 = r_depth - SDW'(1);
    assign depth_m2 = r_depth - SDW'(2);

    // Neighbor of the top frame in its current direction; off-grid is a wall
    always_comb begin
        nr      = top_r;
        nc      = top_c;
        nb_wall = 1'b1;
        unique case (r_top_dir)
            gmds_pkg::DIR_DOWN: begin
                nr      = top_r + DW'(1);
                nb_wall = !(nr < i_rows_used);
            end
            gmds_pkg::DIR_RIGHT: begin
                nc      = top_c + DW'(1);
                nb_wall = !(nc < i_cols_used);
            end
            gmds_pkg::DIR_UP: begin
                nr      = top_r - DW'(1);
                nb_wall = (top_r == '0);
            end
            gmds_pkg::DIR_LEFT: begin
                nc      = top_c - DW'(1);
                nb_wall = (top_c == '0);
            end
            default: begin
                nb_wall = 1'b1;
            end
        endcase
    end

    // Maze memory port selection
    always_comb begin
        mz_we    = 1'b0;
        mz_waddr = top_addr;
        mz_wdata = gmds_pkg::CH_SEEN;
        mz_raddr = nb_addr;
        unique case (i_uw.mz)
            gmds_pkg::MZ_RD_REQ: begin
                mz_raddr = req_addr;
            end
            gmds_pkg::MZ_WR_REQ: begin
                mz_we    = 1'b1;
                mz_waddr = req_addr;
                mz_wdata = i_req_char;
            end
            gmds_pkg::MZ_WR_SEEN_START: begin
                mz_we    = 1'b1;
                mz_waddr = start_addr;
            end
            gmds_pkg::MZ_RD_NB: begin
                mz_raddr = nb_addr;
            end
            gmds_pkg::MZ_WR_SEEN_NB: begin
                mz_we    = 1'b1;
                mz_waddr = nb_addr;
            end
            gmds_pkg::MZ_WR_DEAD_TOP: begin
                mz_we    = 1'b1;
                mz_waddr = top_addr;
                mz_wdata = gmds_pkg::CH_DEAD;
            end
            default: begin
                mz_we = 1'b0;
            end
        endcase
    end

    // Top frame and stack pointer
    always_comb begin
        n_top_row = r_top_row;
        n_top_col = r_top_col;
        n_top_dir = r_top_dir;
        n_nb_row  = r_nb_row;
        n_nb_col  = r_nb_col;
        n_depth   = r_depth;
        st_we     = 1'b0;
        unique case (i_uw.st)
            gmds_pkg::ST_INIT: begin
                n_top_row = start_r[RW-1:0];
                n_top_col = start_c[CW-1:0];
                n_top_dir = gmds_pkg::DIR_DOWN;
                n_depth   = SDW'(1);
            end
            gmds_pkg::ST_NEXT: begin
                n_nb_row  = nr[RW-1:0];
                n_nb_col  = nc[CW-1:0];
                n_top_dir = r_top_dir + XW'(1);
            end
            gmds_pkg::ST_PUSH: begin
                st_we     = 1'b1;
                n_top_row = r_nb_row;
                n_top_col = r_nb_col;
                n_top_dir = gmds_pkg::DIR_DOWN;
                n_depth   = r_depth + SDW'(1);
            end
            gmds_pkg::ST_POP: begin
                n_depth = depth_m1;
            end
            gmds_pkg::ST_LOAD: begin
                {n_top_row, n_top_col, n_top_dir} = st_rdata;
            end
            gmds_pkg::ST_CLEAR: begin
                n_depth = '0;
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_row <= n_top_row;
        r_top_col <= n_top_col;
        r_top_dir <= n_top_dir;
        r_nb_row  <= n_nb_row;
        r_nb_col  <= n_nb_col;
    end

    gmds_ram #(
        .WIDTH (gmds_pkg::CHAR_W),
        .DEPTH (1 << AW)
    ) u_maze (
        .i_clk   (i_clk),
        .i_we    (mz_we),
        .i_waddr (mz_waddr),
        .i_wdata (mz_wdata),
        .i_raddr (mz_raddr),
        .o_rdata (mz_rdata)
    );

    // Frames below the top one; the top frame lives in registers
    gmds_ram #(
        .WIDTH (FW),
        .DEPTH (CELLS)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (depth_m1[SAW-1:0]),
        .i_wdata ({r_top_row, r_top_col, r_top_dir}),
        .i_raddr (depth_m2[SAW-1:0]),
        .o_rdata (st_rdata)
    );

    assign o_mz_rdata        = mz_rdata;
    assign o_stat.start_goal = gmds_pkg::is_goal(start_r, start_c, i_rows_used, i_cols_used);
    assign o_stat.empty      = (r_depth == '0);
    assign o_stat.dir_done   = (r_top_dir == gmds_pkg::DIR_DONE);
    assign o_stat.nb_wall    = nb_wall;
    assign o_stat.nb_closed  = (mz_rdata != gmds_pkg::CH_OPEN);
    assign o_stat.nb_goal    = gmds_pkg::is_goal(DW'(r_nb_row), DW'(r_nb_col),
                                                 i_rows_used, i_cols_used);

    // Each cell is entered at most once, so the stack never overflows
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= SDW'(CELLS))
        else $error("search stack depth beyond cell count");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_uw.st == gmds_pkg::ST_PUSH) |-> (r_depth < SDW'(CELLS)))
        else $error("push on a full search stack");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_depth != '0) |-> (r_top_dir <= gmds_pkg::DIR_DONE))
        else $error("top frame direction out of range");

endmodule
`default_nettype wire

>>> hdl/grid_maze_dfs_solver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_maze_dfs_solver - character grid maze with depth-first search solver
// Cell write/read requests and a solve command over one request channel.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries one word: req_type,
//   cell_row, cell_col, cell_char. Write stores a character, read returns
//   it, solve searches from (start_row, start_col) to (rows-2, cols-1),
//   marking entered cells '#' and dead ends '/'.
//   Every request yields exactly one word on the response channel
//   (o_out_valid / i_out_ready): read_char, goal_found, status.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; write it
//   only while no request is in flight.
//   Sequencing: each request runs as a sequence of microcode steps from
//   accept to response valid, and a solve repeats steps for each wall
//   direction, closed neighbor, cell entered and backtrack, all set by the
//   microcode step counter walking one step per cycle against the maze
//   memory with one write and one read port. One request is in
//   work at a time; the next one is taken while a finished response still
//   waits in the output register.
//   Reset: sequencer returns to idle, stack empties, goal flag clears and
//   config returns to 64x64 with start (1,0). The maze memory is not
//   cleared; every cell must be written before it is read or solved.
//   A stalled receiver holds the response and blocks the next response.
// ----------------------------------------------------------------------------
module grid_maze_dfs_solver #(
    parameter int MAX_ROWS = gmds_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = gmds_pkg::MAX_COLS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [gmds_pkg::REQ_W-1:0]      i_req_type,
    input  wire logic [gmds_pkg::COORD_W-1:0]    i_cell_row,
    input  wire logic [gmds_pkg::COORD_W-1:0]    i_cell_col,
    input  wire logic [gmds_pkg::CHAR_W-1:0]     i_cell_char,
    // response channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [gmds_pkg::CHAR_W-1:0]     o_read_char,
    output logic                                 o_goal_found,
    output logic                                 o_status,
    // configuration channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [gmds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [gmds_pkg::COUNT_W-1:0]    i_cfg_data
);

    localparam int DW = gmds_pkg::DIM_W;
    localparam logic [DW-1:0] MAXR = DW'(MAX_ROWS);
    localparam logic [DW-1:0] MAXC = DW'(MAX_COLS);

    // Configuration registers
    logic [gmds_pkg::COUNT_W-1:0] r_row_count, r_col_count;
    logic [gmds_pkg::COORD_W-1:0] r_start_row, r_start_col;

    // Latched request
    logic [gmds_pkg::REQ_W-1:0]   r_req;
    logic [gmds_pkg::COORD_W-1:0] r_row, r_col;
    logic [gmds_pkg::CHAR_W-1:0]  r_char;

    // Response being built, goal flag, and output register
    logic [gmds_pkg::CHAR_W-1:0]  r_rd, n_rd;
    logic                         r_status, n_status;
    logic                         r_found, n_found;
    logic                         r_out_valid, n_out_valid;
    logic [gmds_pkg::CHAR_W-1:0]  r_out_char, n_out_char;
    logic                         r_out_found, n_out_found;
    logic                         r_out_status, n_out_status;

    gmds_pkg::t_uword   uw;
    gmds_pkg::t_flags   flags;
    gmds_pkg::t_dp_stat dp_stat;
    logic [gmds_pkg::CHAR_W-1:0] mz_rdata;

    logic [DW-1:0] rows_used, cols_used;
    logic          in_acc, out_busy;

    // Saturate counts to the grid size
    assign rows_used = (DW'(r_row_count) > MAXR) ? MAXR : DW'(r_row_count);
    assign cols_used = (DW'(r_col_count) > MAXC) ? MAXC : DW'(r_col_count);

    assign o_in_ready = uw.in_rdy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_busy   = r_out_valid && !i_out_ready;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= gmds_pkg::COUNT_W'(64);
            r_col_count <= gmds_pkg::COUNT_W'(64);
            r_start_row <= gmds_pkg::COORD_W'(1);
            r_start_col <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                gmds_pkg::CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                gmds_pkg::CFG_COL_COUNT: r_col_count <= i_cfg_data;
                gmds_pkg::CFG_START_ROW: r_start_row <= i_cfg_data[gmds_pkg::COORD_W-1:0];
                gmds_pkg::CFG_START_COL: r_start_col <= i_cfg_data[gmds_pkg::COORD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Hold the request word for the whole sequence
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req  <= i_req_type;
            r_row  <= i_cell_row;
            r_col  <= i_cell_col;
            r_char <= i_cell_char;
        end
    end

    // Condition flags for the sequencer
    always_comb begin
        flags.not_acc    = !in_acc;
        flags.req_solve  = (r_req == gmds_pkg::REQ_SOLVE);
        flags.req_unk    = (r_req != gmds_pkg::REQ_WRITE) && (r_req != gmds_pkg::REQ_READ) &&
                           (r_req != gmds_pkg::REQ_SOLVE);
        flags.req_out    = !((DW'(r_row) < rows_used) && (DW'(r_col) < cols_used));
        flags.req_write  = (r_req == gmds_pkg::REQ_WRITE);
        flags.start_out  = !((DW'(r_start_row) < rows_used) && (DW'(r_start_col) < cols_used));
        flags.start_goal = dp_stat.start_goal;
        flags.empty      = dp_stat.empty;
        flags.dir_done   = dp_stat.dir_done;
        flags.nb_wall    = dp_stat.nb_wall;
        flags.nb_closed  = dp_stat.nb_closed;
        flags.nb_goal    = dp_stat.nb_goal;
        flags.out_busy   = out_busy;
    end

    // Response fields and output register
    always_comb begin
        n_rd         = r_rd;
        n_status     = r_status;
        n_found      = r_found;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_char   = r_out_char;
        n_out_found  = r_out_found;
        n_out_status = r_out_status;
        if (in_acc) begin
            n_rd     = '0;
            n_status = 1'b0;
        end
        unique case (uw.res)
            gmds_pkg::RES_CAPTURE:  n_rd = mz_rdata;
            gmds_pkg::RES_BAD:      n_status = 1'b1;
            gmds_pkg::RES_FLAG_CLR: n_found = 1'b0;
            gmds_pkg::RES_FLAG_SET: n_found = 1'b1;
            gmds_pkg::RES_BAD_CLR: begin
                n_status = 1'b1;
                n_found  = 1'b0;
            end
            gmds_pkg::RES_SEND: begin
                // load only once the previous word has drained
                if (!out_busy) begin
                    n_out_valid  = 1'b1;
                    n_out_char   = r_rd;
                    n_out_found  = r_found;
                    n_out_status = r_status;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd         <= n_rd;
        r_status     <= n_status;
        r_out_char   <= n_out_char;
        r_out_found  <= n_out_found;
        r_out_status <= n_out_status;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_char  = r_out_char;
    assign o_goal_found = r_out_found;
    assign o_status     = r_out_status;

    gmds_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uw    (uw)
    );

    gmds_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_uw        (uw),
        .i_rows_used (rows_used),
        .i_cols_used (cols_used),
        .i_start_row (r_start_row),
        .i_start_col (r_start_col),
        .i_req_row   (r_row),
        .i_req_col   (r_col),
        .i_req_char  (r_char),
        .o_mz_rdata  (mz_rdata),
        .o_stat      (dp_stat)
    );

    // After taking a word, drop ready until its response is queued
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("request taken while another is in work");

    // Idle implies the search stack has unwound
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> dp_stat.empty)
        else $error("idle with a non-empty search stack");

    // A response load never overwrites an unaccepted word
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (uw.res == gmds_pkg::RES_SEND && out_busy) |=> $stable(r_out_char))
        else $error("response overwritten while stalled");

endmodule
`default_nettype wire

>>> sim/gmds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmds_checker - response predictor and scoreboard for the grid maze solver
// Watches the configuration, request and response channels. Mirrors the
// maze, its registers and the depth-first search, predicts one response word
// per request word and compares each response word against the oldest
// prediction.
// ----------------------------------------------------------------------------
module gmds_checker
    import gmds_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [COORD_W-1:0]   i_cell_row,
    input  logic [COORD_W-1:0]   i_cell_col,
    input  logic [CHAR_W-1:0]    i_cell_char,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [CHAR_W-1:0]    i_read_char,
    input  logic                 i_goal_found,
    input  logic                 i_status,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    output int                   o_fail_count,
    output int                   o_pending
);

    localparam int GRID_SLOTS = MAX_ROWS * MAX_COLS;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic              goal_found;
        logic              status;
    } t_reply;

    logic [COUNT_W-1:0] row_count;
    logic [COUNT_W-1:0] col_count;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] start_col;

    logic [CHAR_W-1:0]  grid      [GRID_SLOTS];
    int unsigned        trail_pos [GRID_SLOTS];
    logic [DIR_W-1:0]   trail_dir [GRID_SLOTS];
    int unsigned        trail_depth;
    logic               goal_flag;
    t_reply             replies_due [$];
    int                 fail_total;

    function automatic int unsigned rows_in_use();
        return (row_count > MAX_ROWS) ? MAX_ROWS : row_count;
    endfunction

    function automatic int unsigned cols_in_use();
        return (col_count > MAX_COLS) ? MAX_COLS : col_count;
    endfunction

    function automatic bit on_grid(int unsigned r, int unsigned c);
        return (r < rows_in_use()) && (c < cols_in_use());
    endfunction

    // Neighbor of pos in direction d; anything off the grid is a wall
    function automatic bit step_to(int unsigned pos, logic [DIR_W-1:0] d,
                                   output int unsigned nb);
        int unsigned r;
        int unsigned c;
        r  = pos / MAX_COLS;
        c  = pos % MAX_COLS;
        nb = 0;
        case (d)
            DIR_DOWN:  r = r + 1;
            DIR_RIGHT: c = c + 1;
            DIR_UP: begin
                if (r == 0) return 1'b0;
                r = r - 1;
            end
            default: begin
                if (c == 0) return 1'b0;
                c = c - 1;
            end
        endcase
        if (!on_grid(r, c)) return 1'b0;
        nb = r * MAX_COLS + c;
        return 1'b1;
    endfunction

    function automatic bit opens_toward(int unsigned pos, logic [DIR_W-1:0] d);
        int unsigned nb;
        if (!step_to(pos, d, nb)) return 1'b0;
        return grid[nb] == CH_OPEN;
    endfunction

    function automatic bit at_goal(int unsigned pos);
        int unsigned rows;
        int unsigned cols;
        rows = rows_in_use();
        cols = cols_in_use();
        return (rows >= 2) && (cols >= 1) &&
               (pos / MAX_COLS == rows - 2) && (pos % MAX_COLS == cols - 1);
    endfunction

    // Mark a cell entered; push it unless it is the goal
    function automatic bit enter_spot(int unsigned pos);
        grid[pos] = CH_SEEN;
        if (at_goal(pos)) return 1'b1;
        if (trail_depth < GRID_SLOTS) begin
            trail_pos[trail_depth] = pos;
            trail_dir[trail_depth] = DIR_DOWN;
            trail_depth++;
        end
        return 1'b0;
    endfunction

    function automatic void search_from(int unsigned origin);
        int unsigned      here;
        int unsigned      nb;
        logic [DIR_W-1:0] d;
        trail_depth = 0;
        goal_flag   = 1'b0;
        if (enter_spot(origin)) begin
            goal_flag = 1'b1;
            return;
        end
        while (trail_depth > 0) begin
            here = trail_pos[trail_depth-1];
            d    = trail_dir[trail_depth-1];
            if (d != DIR_DONE) begin
                trail_dir[trail_depth-1] = d + 1'b1;
                if (step_to(here, d, nb)) begin
                    if (grid[nb] == CH_OPEN) begin
                        if (enter_spot(nb)) begin
                            goal_flag   = 1'b1;
                            trail_depth = 0;
                            return;
                        end
                    end
                end
            end else begin
                if (!opens_toward(here, DIR_DOWN) && !opens_toward(here, DIR_RIGHT) &&
                    !opens_toward(here, DIR_UP) && !opens_toward(here, DIR_LEFT))
                    grid[here] = CH_DEAD;
                trail_depth--;
            end
        end
    endfunction

    function automatic t_reply predict_reply(logic [REQ_W-1:0] req, logic [COORD_W-1:0] r,
                                             logic [COORD_W-1:0] c, logic [CHAR_W-1:0] ch);
        t_reply rep;
        rep = '0;
        case (req)
            REQ_WRITE, REQ_READ: begin
                if (!on_grid(r, c))
                    rep.status = 1'b1;
                else if (req == REQ_WRITE)
                    grid[r * MAX_COLS + c] = ch;
                else
                    rep.read_char = grid[r * MAX_COLS + c];
            end
            REQ_SOLVE: begin
                if (!on_grid(start_row, start_col)) begin
                    goal_flag  = 1'b0;
                    rep.status = 1'b1;
                end else begin
                    search_from(start_row * MAX_COLS + start_col);
                end
            end
            default: ;
        endcase
        rep.goal_found = goal_flag;
        return rep;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            row_count   = 7'd64;
            col_count   = 7'd64;
            start_row   = 6'd1;
            start_col   = 6'd0;
            goal_flag   = 1'b0;
            trail_depth = 0;
            fail_total  = 0;
            replies_due.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ROW_COUNT: row_count = i_cfg_data;
                    CFG_COL_COUNT: col_count = i_cfg_data;
                    CFG_START_ROW: start_row = i_cfg_data[COORD_W-1:0];
                    CFG_START_COL: start_col = i_cfg_data[COORD_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready)
                replies_due.push_back(predict_reply(i_req_type, i_cell_row, i_cell_col,
                                                    i_cell_char));
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected response word, expected none, actual %h/%b/%b",
                             $time, i_read_char, i_goal_found, i_status);
                    fail_total++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("read_char", want.read_char, i_read_char);
                    check_field("goal_found", want.goal_found, i_goal_found);
                    check_field("status", want.status, i_status);
                end
            end
            o_pending <= replies_due.size();
        end
        o_fail_count <= fail_total;
    end

endmodule

>>> sim/tb_grid_maze_dfs_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_maze_dfs_solver - self-checking bench for the grid maze solver
// Drives cell writes, reads, solves and unknown requests through the request
// channel and reprograms the grid size and start cell between bursts. A
// checker instance beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_grid_maze_dfs_solver;
    import gmds_pkg::*;

    // Request code the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam int GRID_ROWS    = MAX_ROWS_DEF;
    localparam int GRID_COLS    = MAX_COLS_DEF;
    localparam int RANDOM_WORDS = 400;
    // Largest solved grid is 144 cells; keep a wide margin
    localparam int STALL_LIMIT  = 50000;
    localparam int DRAIN_CYCLES = 20;
    // Keep random grids small so solves stay short
    localparam int MAX_AREA     = 160;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [REQ_W-1:0]     i_req_type;
    logic [COORD_W-1:0]   i_cell_row;
    logic [COORD_W-1:0]   i_cell_col;
    logic [CHAR_W-1:0]    i_cell_char;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [CHAR_W-1:0]    o_read_char;
    logic                 o_goal_found;
    logic                 o_status;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COUNT_W-1:0]   i_cfg_data;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;
    int quiet_cycles;
    // Word count at the start of the random part
    int unsigned first_random;

    // Stimulus-side copy of the registers, used to plan legal traffic
    logic [COUNT_W-1:0] cur_rows;
    logic [COUNT_W-1:0] cur_cols;
    // Cells that hold a known character; reads and solves only touch these
    bit                 cell_written [GRID_ROWS*GRID_COLS];

    grid_maze_dfs_solver uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_cell_row   (i_cell_row),
        .i_cell_col   (i_cell_col),
        .i_cell_char  (i_cell_char),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_char  (o_read_char),
        .o_goal_found (o_goal_found),
        .o_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    gmds_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_cell_row   (i_cell_row),
        .i_cell_col   (i_cell_col),
        .i_cell_char  (i_cell_char),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_read_char  (o_read_char),
        .i_goal_found (o_goal_found),
        .i_status     (o_status),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Response side: stall at the rate of the current idling phase
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles in which no word moves on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_grid_maze_dfs_solver failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic int unsigned span(logic [COUNT_W-1:0] n, int unsigned limit);
        return (n > limit) ? limit : n;
    endfunction

    function automatic int unsigned rows_now();
        return span(cur_rows, GRID_ROWS);
    endfunction

    function automatic int unsigned cols_now();
        return span(cur_cols, GRID_COLS);
    endfunction

    function automatic bit on_grid(int unsigned r, int unsigned c);
        return (r < rows_now()) && (c < cols_now());
    endfunction

    // True once every cell in use holds a known character
    function automatic bit grid_complete();
        for (int r = 0; r < rows_now(); r++)
            for (int c = 0; c < cols_now(); c++)
                if (!cell_written[r * GRID_COLS + c]) return 1'b0;
        return 1'b1;
    endfunction

    // Mostly small counts, with zero and saturating counts now and then
    function automatic logic [COUNT_W-1:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) return '0;
        if (roll < 16) return COUNT_W'($urandom_range(127, 64));
        if (roll < 28) return COUNT_W'($urandom_range(12, 7));
        return COUNT_W'($urandom_range(6, 1));
    endfunction

    // Maze content: mostly open, some walls, some marks and arbitrary bytes
    function automatic logic [CHAR_W-1:0] maze_char();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 62) return CH_OPEN;
        if (roll < 85) return 8'h58;
        if (roll < 89) return CH_SEEN;
        if (roll < 92) return CH_DEAD;
        return CHAR_W'($urandom);
    endfunction

    // Send one request word. Caller stands on a clock edge; return on the
    // edge that accepts the word. Hold valid across words unless idling.
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [COORD_W-1:0] r,
                                input logic [COORD_W-1:0] c, input logic [CHAR_W-1:0] ch);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_cell_row  <= r;
        i_cell_col  <= c;
        i_cell_char <= ch;
        do @(posedge i_clk); while (!o_in_ready);
        if (req == REQ_WRITE && on_grid(r, c))
            cell_written[r * GRID_COLS + c] = 1'b1;
        words_sent++;
    endtask

    // Drop valid and hold off until every predicted response word is back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Write one register; valid stays high for back-to-back writes
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COUNT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Reprogram all four registers with the block idle
    task automatic program_grid(input logic [COUNT_W-1:0] rows, input logic [COUNT_W-1:0] cols,
                                input logic [COORD_W-1:0] srow, input logic [COORD_W-1:0] scol);
        wait_drained();
        write_register(CFG_ROW_COUNT, rows);
        write_register(CFG_COL_COUNT, cols);
        write_register(CFG_START_ROW, COUNT_W'(srow));
        write_register(CFG_START_COL, COUNT_W'(scol));
        i_cfg_valid <= 1'b0;
        cur_rows = rows;
        cur_cols = cols;
    endtask

    // Unknown requests, off-grid accesses and readback of known cells
    task automatic send_noise();
        int unsigned roll;
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        rows = rows_now();
        cols = cols_now();
        roll = $urandom_range(2);
        r    = $urandom_range(GRID_ROWS-1);
        c    = $urandom_range(GRID_COLS-1);
        if (roll == 1 && (rows < GRID_ROWS || cols < GRID_COLS)) begin
            // push one coordinate past the edge of the grid in use
            if (rows < GRID_ROWS && (cols == GRID_COLS || $urandom_range(1)))
                r = $urandom_range(GRID_ROWS-1, rows);
            else
                c = $urandom_range(GRID_COLS-1, cols);
            send_request($urandom_range(1) ? REQ_WRITE : REQ_READ, COORD_W'(r), COORD_W'(c),
                         CHAR_W'($urandom));
        end else if (roll == 2 && rows > 0 && cols > 0) begin
            r = $urandom_range(rows-1);
            c = $urandom_range(cols-1);
            if (cell_written[r * GRID_COLS + c])
                send_request(REQ_READ, COORD_W'(r), COORD_W'(c), CHAR_W'($urandom));
            else
                send_request(REQ_UNKNOWN, COORD_W'(r), COORD_W'(c), CHAR_W'($urandom));
        end else begin
            send_request(REQ_UNKNOWN, COORD_W'(r), COORD_W'(c), CHAR_W'($urandom));
        end
    endtask

    // Pick a grid and a start cell for the next maze
    task automatic pick_grid();
        logic [COUNT_W-1:0] rows;
        logic [COUNT_W-1:0] cols;
        logic [COORD_W-1:0] srow;
        logic [COORD_W-1:0] scol;
        int unsigned        ru;
        int unsigned        cu;
        int unsigned        roll;
        rows = pick_count();
        cols = pick_count();
        ru   = span(rows, GRID_ROWS);
        cu   = span(cols, GRID_COLS);
        if (ru * cu > MAX_AREA) begin
            // a long thin maze keeps the solve short
            if ($urandom_range(1))
                rows = COUNT_W'($urandom_range(2, 1));
            else
                cols = COUNT_W'($urandom_range(2, 1));
            ru = span(rows, GRID_ROWS);
            cu = span(cols, GRID_COLS);
        end
        roll = $urandom_range(99);
        if (ru >= 2 && cu >= 1 && roll < 10) begin
            srow = COORD_W'(ru - 2);
            scol = COORD_W'(cu - 1);
        end else if (ru > 0 && cu > 0 && roll < 88) begin
            srow = COORD_W'($urandom_range(ru - 1));
            scol = COORD_W'($urandom_range(cu - 1));
        end else begin
            srow = COORD_W'($urandom);
            scol = COORD_W'($urandom);
        end
        program_grid(rows, cols, srow, scol);
    endtask

    // Idling phases over the random part: none, sender, receiver, both
    task automatic set_idling(input int unsigned progress);
        if (progress < RANDOM_WORDS / 4) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end else if (progress < RANDOM_WORDS / 2) begin
            send_idle_pct  = 47;
            recv_stall_pct = 0;
        end else if (progress < 3 * RANDOM_WORDS / 4) begin
            send_idle_pct  = 0;
            recv_stall_pct = 47;
        end else begin
            send_idle_pct  = 27;
            recv_stall_pct = 27;
        end
    endtask

    // Write every cell in use, with a little noise mixed in
    task automatic lay_out_maze();
        for (int r = 0; r < rows_now(); r++) begin
            for (int c = 0; c < cols_now(); c++) begin
                // follow the phase boundaries even inside a large maze
                set_idling(words_sent - first_random);
                if ($urandom_range(99) < 5) send_noise();
                send_request(REQ_WRITE, COORD_W'(r), COORD_W'(c), maze_char());
            end
        end
    endtask

    initial begin
        int unsigned rounds;

        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_req_type     = REQ_WRITE;
        i_cell_row     = '0;
        i_cell_col     = '0;
        i_cell_char    = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_ROW_COUNT;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        words_sent     = 0;
        first_random   = 0;
        cur_rows       = 7'd64;
        cur_cols       = 7'd64;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full 64x64 grid out of reset: touch the far corners, no solve
        send_request(REQ_WRITE, 6'd63, 6'd63, 8'hFF);
        send_request(REQ_READ, 6'd63, 6'd63, 8'h00);
        send_request(REQ_WRITE, 6'd0, 6'd0, 8'h00);
        send_request(REQ_READ, 6'd0, 6'd0, 8'hFF);
        send_request(REQ_UNKNOWN, 6'd63, 6'd0, 8'hA5);

        // Zero counts leave no cell in use: everything is off the grid
        program_grid(7'd0, 7'd0, 6'd0, 6'd0);
        send_request(REQ_WRITE, 6'd0, 6'd0, CH_OPEN);
        send_request(REQ_READ, 6'd0, 6'd0, 8'h00);
        send_request(REQ_SOLVE, 6'd0, 6'd0, 8'h00);

        // Oversized counts saturate to the full grid
        program_grid(7'd127, 7'd127, 6'd63, 6'd63);
        send_request(REQ_READ, 6'd63, 6'd63, 8'h00);

        // Last column falls off a 63-column grid
        program_grid(7'd64, 7'd63, 6'd0, 6'd0);
        send_request(REQ_WRITE, 6'd0, 6'd63, CH_OPEN);

        // 2x2 maze with the goal at (0,1): down is a wall, right reaches it
        program_grid(7'd2, 7'd2, 6'd0, 6'd0);
        send_request(REQ_WRITE, 6'd0, 6'd0, CH_OPEN);
        send_request(REQ_WRITE, 6'd0, 6'd1, CH_OPEN);
        send_request(REQ_WRITE, 6'd1, 6'd0, 8'h58);
        send_request(REQ_WRITE, 6'd1, 6'd1, CH_OPEN);
        send_request(REQ_SOLVE, 6'd0, 6'd0, 8'h00);
        send_request(REQ_READ, 6'd0, 6'd1, 8'h00);
        // goal flag must survive an ignored request
        send_request(REQ_UNKNOWN, 6'd0, 6'd0, 8'h00);

        // Start on the goal itself
        program_grid(7'd2, 7'd2, 6'd0, 6'd1);
        send_request(REQ_SOLVE, 6'd0, 6'd0, 8'h00);

        // Single row has no goal: solve only marks cells
        program_grid(7'd1, 7'd3, 6'd0, 6'd0);
        send_request(REQ_WRITE, 6'd0, 6'd1, CH_OPEN);
        send_request(REQ_WRITE, 6'd0, 6'd2, CH_OPEN);
        send_request(REQ_SOLVE, 6'd0, 6'd0, 8'h00);
        send_request(REQ_READ, 6'd0, 6'd2, 8'h00);

        // Random mazes: reprogram, fill, solve, read back, with noise
        first_random = words_sent;
        rounds       = 0;
        while (words_sent < first_random + RANDOM_WORDS) begin
            set_idling(words_sent - first_random);
            if (rounds == 0 || $urandom_range(99) < 60)
                pick_grid();
            if (!grid_complete() || $urandom_range(99) < 85)
                lay_out_maze();
            send_request(REQ_SOLVE, COORD_W'($urandom), COORD_W'($urandom),
                         CHAR_W'($urandom));
            repeat ($urandom_range(4)) send_noise();
            // solve again over the marked maze now and then
            if ($urandom_range(99) < 15)
                send_request(REQ_SOLVE, COORD_W'($urandom), COORD_W'($urandom),
                             CHAR_W'($urandom));
            rounds++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_grid_maze_dfs_solver passed");
        else
            $display("tb_grid_maze_dfs_solver failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/gmds_pkg.sv
hdl/gmds_ram.sv
hdl/gmds_seq.sv
hdl/gmds_dp.sv
hdl/grid_maze_dfs_solver.sv
sim/gmds_checker.sv
sim/tb_grid_maze_dfs_solver.sv
